// ===== src/charstring_assembler_stream_macros.svh =====
// Assertion helpers shared by the charstring assembler files.
`ifndef CHARSTRING_ASSEMBLER_STREAM_MACROS_SVH
`define CHARSTRING_ASSEMBLER_STREAM_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define CSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/csa_pkg.sv =====
// ----------------------------------------------------------------------------
// csa_pkg
// Types, character codes and the command name table of the charstring
// assembler.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int RES_MAX = 12;
  localparam int RES_CW  = 4;
  localparam int TOK_BYTES = 16;
  localparam int OP_NUM = 26;

  typedef enum logic [3:0] {
    ST_CHAR        = 4'd0,
    ST_DONE        = 4'd1,
    ST_EOF_STR     = 4'd2,
    ST_STRAY_PAREN = 4'd3,
    ST_NESTED_CS   = 4'd4,
    ST_STRAY_ANGLE = 4'd5,
    ST_TYPECHECK   = 4'd6,
    ST_UNKNOWN_CMD = 4'd7,
    ST_NEST_OVF    = 4'd8
  } status_e;

  typedef enum logic [4:0] {
    SM_IDLE    = 5'b00001,
    SM_COMMENT = 5'b00010,
    SM_STRING  = 5'b00100,
    SM_ESCAPE  = 5'b01000,
    SM_TOKEN   = 5'b10000
  } scan_e;

  typedef struct packed {
    logic [7:0] ch;
    status_e    st;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic       two;
    logic [7:0] code;
  } op_hit_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_LBRC   = 8'h7B;
  localparam logic [7:0] CH_RBRC   = 8'h7D;
  localparam logic [7:0] CH_UC_C   = 8'h43;
  localparam logic [7:0] CH_UC_F   = 8'h46;

  // Names are right aligned: the last character sits in the low byte.
  localparam logic [8*TOK_BYTES-1:0] OP_NAME [OP_NUM] = '{
    "hstem", "vstem", "vmoveto", "rlineto", "hlineto", "vlineto",
    "rrcurveto", "closepath", "callsubr", "return", "escape", "hsbw",
    "endchar", "rmoveto", "hmoveto", "vhcurveto", "hvcurveto",
    "dotsection", "vstem3", "hstem3", "seac", "sbw", "div",
    "callothersubr", "pop", "setcurrentpoint"
  };
  localparam logic [3:0] OP_LEN [OP_NUM] = '{
    4'd5, 4'd5, 4'd7, 4'd7, 4'd7, 4'd7, 4'd9, 4'd9, 4'd8, 4'd6, 4'd6, 4'd4,
    4'd7, 4'd7, 4'd7, 4'd9, 4'd9, 4'd10, 4'd6, 4'd6, 4'd4, 4'd3, 4'd3,
    4'd13, 4'd3, 4'd15
  };
  localparam logic OP_TWO [OP_NUM] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1
  };
  localparam logic [7:0] OP_CODE [OP_NUM] = '{
    8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12,
    8'd13, 8'd14, 8'd21, 8'd22, 8'd30, 8'd31, 8'd0, 8'd1, 8'd2, 8'd6, 8'd7,
    8'd12, 8'd16, 8'd17, 8'd33
  };

  function automatic logic [7:0] hex_char(logic [3:0] d);
    hex_char = (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (8'h37 + {4'd0, d});
  endfunction

  // Match the last len bytes of the token against every command name.
  function automatic op_hit_t op_lookup(logic [8*TOK_BYTES-1:0] tok, logic [3:0] len);
    logic [8*TOK_BYTES-1:0] mask;
    op_hit_t r;
    mask = '0;
    r = '0;
    for (int i = 0; i < TOK_BYTES; i++) begin
      if (i < int'(len)) mask[8*i +: 8] = 8'hFF;
    end
    for (int k = 0; k < OP_NUM; k++) begin
      if (OP_LEN[k] == len && ((tok ^ OP_NAME[k]) & mask) == '0) begin
        r.hit  = 1'b1;
        r.two  = OP_TWO[k];
        r.code = OP_CODE[k];
      end
    end
    return r;
  endfunction

endpackage

// ===== src/charstring_assembler_stream.sv =====
// ----------------------------------------------------------------------------
// charstring_assembler_stream
// Streaming assembler of PostScript charstring text into hex encoded bytes.
// ----------------------------------------------------------------------------
// One input item (a text byte or an end marker) is taken per cycle while the
// result list register is free; its whole result list, up to eleven items,
// is formed in the same cycle and then drained one item per cycle while the
// receiver is ready. The next item enters in the cycle the last of its
// results leaves: plain echoed bytes stream at one per cycle while the
// receiver is ready; token ends that expand into hex hold the input until
// their last result leaves. Outside '<' '>' bytes are echoed; inside, tokens
// become Type 1 numbers or command codes. An error or end of input yields
// one status item, after which every further input is accepted and dropped.
`include "charstring_assembler_stream_macros.svh"

module charstring_assembler_stream import csa_pkg::*; #(
  parameter int MAX_TOKEN = 16,
  parameter int NEST_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [3:0] status_o,
  output logic       last_o
);

  localparam int TLW = $clog2(MAX_TOKEN + 1);

  // scanner state
  logic                   cs_q, cs_d;
  scan_e                  sm_q, sm_d;
  logic [NEST_BITS-1:0]   dep_q, dep_d;
  logic [8*TOK_BYTES-1:0] tok_q, tok_d;
  logic [TLW-1:0]         len_q, len_d;
  logic                   tl_q, tl_d;
  logic [31:0]            acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic                   int_q, int_d;
  logic                   halt_q, halt_d;

  res_t              res_list [RES_MAX];
  logic [RES_CW-1:0] res_cnt;
  logic              in_fire;
  logic              do_finish, do_idle, do_add, do_done;
  logic [7:0]        c;
  logic [31:0]       v, mag;
  logic              vneg;
  logic [7:0]        b8;
  logic [15:0]       w16;
  op_hit_t           op;
  res_t              q_item;

  assign in_fire = in_valid_i && in_ready_o;
  assign c       = in_byte_i;

  always_comb begin
    cs_d = cs_q; sm_d = sm_q; dep_d = dep_q; tok_d = tok_q; len_d = len_q;
    tl_d = tl_q; acc_d = acc_q; neg_d = neg_q; int_d = int_q; halt_d = halt_q;
    res_cnt = '0;
    for (int i = 0; i < RES_MAX; i++) res_list[i] = '0;
    do_finish = 1'b0; do_idle = 1'b0; do_add = 1'b0; do_done = 1'b0;
    v = '0; mag = '0; vneg = 1'b0; b8 = '0; w16 = '0; op = '0;

    if (in_fire && !halt_q) begin
      if (end_of_input_i) begin
        if (sm_q == SM_STRING || sm_q == SM_ESCAPE) begin
          res_list[res_cnt] = '{8'd0, ST_EOF_STR}; res_cnt++; halt_d = 1'b1;
        end else begin
          do_finish = (sm_q == SM_TOKEN);
          do_done   = 1'b1;
        end
      end else begin
        case (sm_q)
          SM_COMMENT: begin
            if (!cs_q) begin res_list[res_cnt] = '{c, ST_CHAR}; res_cnt++; end
            if (c == CH_LF) sm_d = SM_IDLE;
          end
          SM_STRING: begin
            res_list[res_cnt] = '{c, ST_CHAR}; res_cnt++;
            if (c == CH_BSLASH) begin
              sm_d = SM_ESCAPE;
            end else if (c == CH_LPAR) begin
              if (dep_q == '1) begin
                res_list[res_cnt] = '{8'd0, ST_NEST_OVF}; res_cnt++; halt_d = 1'b1;
              end else begin
                dep_d = dep_q + 1'b1;
              end
            end else if (c == CH_RPAR) begin
              if (dep_q != '0) dep_d = dep_q - 1'b1;
              if (dep_d == '0) sm_d = SM_IDLE;
            end
          end
          SM_ESCAPE: begin
            res_list[res_cnt] = '{c, ST_CHAR}; res_cnt++;
            sm_d = SM_STRING;
          end
          SM_TOKEN: begin
            if (!(c == CH_NUL || c == CH_TAB || c == CH_LF || c == CH_FF ||
                  c == CH_CR || c == CH_SPACE || c == CH_LPAR || c == CH_RPAR ||
                  c == CH_LT || c == CH_GT || c == CH_LBRK || c == CH_RBRK ||
                  c == CH_LBRC || c == CH_RBRC || c == CH_SLASH || c == CH_PCT)) begin
              if (cs_q) do_add = 1'b1;
              else begin res_list[res_cnt] = '{c, ST_CHAR}; res_cnt++; end
            end else begin
              do_finish = 1'b1;
              do_idle   = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase
      end

      // close the open token and encode it
      if (do_finish) begin
        if (cs_q) begin
          if (int_q) begin
            v    = neg_q ? (32'd0 - acc_q) : acc_q;
            vneg = v[31];
            mag  = vneg ? (32'd0 - v) : v;
            if (v == 32'h8000_0000 || mag > 32'd1131) begin
              res_list[res_cnt] = '{CH_UC_F, ST_CHAR}; res_cnt++;
              res_list[res_cnt] = '{CH_UC_F, ST_CHAR}; res_cnt++;
              for (int i = 7; i >= 0; i--) begin
                res_list[res_cnt] = '{hex_char(v[4*i +: 4]), ST_CHAR}; res_cnt++;
              end
            end else if (mag <= 32'd107) begin
              b8 = vneg ? (8'd139 - mag[7:0]) : (8'd139 + mag[7:0]);
              res_list[res_cnt] = '{hex_char(b8[7:4]), ST_CHAR}; res_cnt++;
              res_list[res_cnt] = '{hex_char(b8[3:0]), ST_CHAR}; res_cnt++;
            end else begin
              w16 = (vneg ? 16'hFB00 : 16'hF700) + mag[15:0] - 16'd108;
              for (int i = 3; i >= 0; i--) begin
                res_list[res_cnt] = '{hex_char(w16[4*i +: 4]), ST_CHAR}; res_cnt++;
              end
            end
          end else begin
            if (!tl_q && int'(len_q) < TOK_BYTES) op = op_lookup(tok_q, len_q[3:0]);
            if (op.hit) begin
              if (op.two) begin
                res_list[res_cnt] = '{CH_ZERO, ST_CHAR}; res_cnt++;
                res_list[res_cnt] = '{CH_UC_C, ST_CHAR}; res_cnt++;
              end
              res_list[res_cnt] = '{hex_char(op.code[7:4]), ST_CHAR}; res_cnt++;
              res_list[res_cnt] = '{hex_char(op.code[3:0]), ST_CHAR}; res_cnt++;
            end else begin
              res_list[res_cnt] = '{8'd0, ST_UNKNOWN_CMD}; res_cnt++; halt_d = 1'b1;
            end
          end
        end
        len_d = '0; tl_d = 1'b0; acc_d = '0; neg_d = 1'b0; int_d = 1'b1;
        sm_d = SM_IDLE;
      end

      // byte seen with no token open
      if (do_idle && !halt_d) begin
        sm_d = SM_IDLE;
        case (c)
          CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE: begin
            if (!cs_d) begin res_list[res_cnt] = '{c, ST_CHAR}; res_cnt++; end
          end
          CH_PCT: begin
            if (!cs_d) begin res_list[res_cnt] = '{c, ST_CHAR}; res_cnt++; end
            sm_d = SM_COMMENT;
          end
          CH_LPAR: begin
            if (cs_d) begin
              res_list[res_cnt] = '{8'd0, ST_TYPECHECK}; res_cnt++; halt_d = 1'b1;
            end else begin
              res_list[res_cnt] = '{c, ST_CHAR}; res_cnt++;
              dep_d = NEST_BITS'(1);
              sm_d  = SM_STRING;
            end
          end
          CH_RPAR: begin
            res_list[res_cnt] = '{8'd0, ST_STRAY_PAREN}; res_cnt++; halt_d = 1'b1;
          end
          CH_LT: begin
            if (cs_d) begin
              res_list[res_cnt] = '{8'd0, ST_NESTED_CS}; res_cnt++; halt_d = 1'b1;
            end else begin
              res_list[res_cnt] = '{c, ST_CHAR}; res_cnt++; cs_d = 1'b1;
            end
          end
          CH_GT: begin
            if (!cs_d) begin
              res_list[res_cnt] = '{8'd0, ST_STRAY_ANGLE}; res_cnt++; halt_d = 1'b1;
            end else begin
              res_list[res_cnt] = '{c, ST_CHAR}; res_cnt++; cs_d = 1'b0;
            end
          end
          CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC: begin
            if (cs_d) begin
              res_list[res_cnt] = '{8'd0, ST_TYPECHECK}; res_cnt++; halt_d = 1'b1;
            end else begin
              res_list[res_cnt] = '{c, ST_CHAR}; res_cnt++;
            end
          end
          default: begin
            len_d = '0; tl_d = 1'b0; acc_d = '0; neg_d = 1'b0; int_d = 1'b1;
            sm_d  = SM_TOKEN;
            if (cs_d) do_add = 1'b1;
            else begin res_list[res_cnt] = '{c, ST_CHAR}; res_cnt++; end
          end
        endcase
      end

      // append one byte to the token: sign, digit or name character
      if (do_add) begin
        if (len_d == '0 && (c == CH_PLUS || c == CH_MINUS)) neg_d = (c == CH_MINUS);
        else if (c >= CH_ZERO && c <= CH_NINE)
          acc_d = {acc_d[28:0], 3'b000} + {acc_d[30:0], 1'b0} + {24'd0, c - CH_ZERO};
        else int_d = 1'b0;
        if (len_d < TLW'(MAX_TOKEN)) begin
          tok_d = {tok_d[8*TOK_BYTES-9:0], c};
          len_d = len_d + 1'b1;
        end else begin
          tl_d = 1'b1;
        end
      end

      if (do_done && !halt_d) begin
        res_list[res_cnt] = '{8'd0, ST_DONE}; res_cnt++; halt_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q   <= 1'b0;
      sm_q   <= SM_IDLE;
      dep_q  <= '0;
      len_q  <= '0;
      tl_q   <= 1'b0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      int_q  <= 1'b1;
      halt_q <= 1'b0;
    end else if (in_fire) begin
      cs_q   <= cs_d;
      sm_q   <= sm_d;
      dep_q  <= dep_d;
      len_q  <= len_d;
      tl_q   <= tl_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      int_q  <= int_d;
      halt_q <= halt_d;
    end
  end

  // token bytes: shift line, only the newest len bytes are ever compared
  always_ff @(posedge clk_i) begin
    if (in_fire) tok_q <= tok_d;
  end

  csa_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .list_i      (res_list),
    .count_i     (res_cnt),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .item_o      (q_item),
    .last_o      (last_o)
  );

  assign out_byte_o = q_item.ch;
  assign status_o   = q_item.st;

  `CSA_ASSERT_NEXT(a_halt_silent, halt_q && in_fire, !out_valid_o, "result after halt")
  `CSA_ASSERT(a_depth_outside, (sm_q == SM_STRING || sm_q == SM_ESCAPE) || dep_q == '0, "depth left open outside a string")

endmodule

// ===== src/csa_outq.sv =====
// ----------------------------------------------------------------------------
// csa_outq
// Result list register: holds the items of one input and drains them in order.
// ----------------------------------------------------------------------------
`include "charstring_assembler_stream_macros.svh"

module csa_outq import csa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  res_t              list_i [RES_MAX],
  input  logic [RES_CW-1:0] count_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              item_o,
  output logic              last_o
);

  res_t              list_q [RES_MAX];
  logic [RES_CW-1:0] cnt_q, rd_q;
  logic              pop;

  assign out_valid_o = rd_q < cnt_q;
  assign pop         = out_valid_o && out_ready_i;
  assign last_o      = (rd_q + 1'b1) == cnt_q;
  // free once empty, or when the final item leaves this cycle
  assign ready_o     = !out_valid_o || (last_o && out_ready_i);
  assign item_o      = out_valid_o ? list_q[rd_q] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= count_i;
      rd_q  <= '0;
    end else if (pop) begin
      rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) list_q <= list_i;
  end

  `CSA_ASSERT(a_rd_bound, rd_q <= cnt_q && cnt_q <= RES_CW'(RES_MAX), "read index past count")
  `CSA_ASSERT_NEXT(a_pop_adv, pop && !load_i, rd_q == $past(rd_q) + 1'b1, "drain did not advance")

endmodule

// ===== verif/charstring_assembler_checker.sv =====
// ----------------------------------------------------------------------------
// charstring_assembler_checker
// Watches both channels of the charstring assembler, predicts the result
// items of every accepted input item and compares them in order.
// ----------------------------------------------------------------------------
module charstring_assembler_checker import csa_pkg::*; #(
  parameter int MAX_TOKEN = 16,
  parameter int NEST_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic [3:0] status_i,
  input  logic       last_i,
  output int         errors_o,
  output int         pending_o,
  output int         checked_o
);

  typedef struct {
    logic [7:0] ch;
    logic [3:0] st;
    logic       last;
  } outcome_t;

  // Command names with their codes; from CMD_ESC_FIRST on, the escaped (0C xx) form.
  localparam int NUM_CMDS = 26;
  localparam string CMD_NAME [NUM_CMDS] = '{
    "hstem", "vstem", "vmoveto", "rlineto", "hlineto", "vlineto", "rrcurveto",
    "closepath", "callsubr", "return", "escape", "hsbw", "endchar", "rmoveto",
    "hmoveto", "vhcurveto", "hvcurveto", "dotsection", "vstem3", "hstem3",
    "seac", "sbw", "div", "callothersubr", "pop", "setcurrentpoint"
  };
  localparam logic [7:0] CMD_CODE [NUM_CMDS] = '{
    8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13,
    8'd14, 8'd21, 8'd22, 8'd30, 8'd31, 8'd0, 8'd1, 8'd2, 8'd6, 8'd7, 8'd12,
    8'd16, 8'd17, 8'd33
  };
  localparam int CMD_ESC_FIRST = 17;

  logic                  in_cs;
  scan_e                 mode;
  longint unsigned       depth;
  logic [7:0]            tok [MAX_TOKEN];
  int                    tok_len;
  logic                  tok_long;
  logic [31:0]           acc;
  logic                  neg;
  logic                  is_int;
  logic                  stopped;
  outcome_t              step_q [$];
  outcome_t              result_q [$];

  function automatic bit is_ws(logic [7:0] c);
    return c == CH_NUL || c == CH_TAB || c == CH_LF || c == CH_FF ||
           c == CH_CR || c == CH_SPACE;
  endfunction

  function automatic bit is_reg(logic [7:0] c);
    return !is_ws(c) && !(c inside {CH_LPAR, CH_RPAR, CH_LT, CH_GT, CH_LBRK,
                                    CH_RBRK, CH_LBRC, CH_RBRC, CH_SLASH, CH_PCT});
  endfunction

  function automatic void emit(logic [7:0] c, status_e st);
    outcome_t o;
    o.ch   = c;
    o.st   = st;
    o.last = 1'b0;
    if (step_q.size() < RES_MAX) step_q.push_back(o);
  endfunction

  function automatic void fail_with(status_e st);
    emit(8'h00, st);
    stopped = 1'b1;
  endfunction

  function automatic void emit_hex(logic [31:0] v, int digits);
    logic [3:0] d;
    for (int i = digits - 1; i >= 0; i--) begin
      d = v[4*i +: 4];
      emit((d < 4'd10) ? 8'h30 + d : 8'h41 + d - 8'd10, ST_CHAR);
    end
  endfunction

  function automatic void clear_token();
    tok_len  = 0;
    tok_long = 1'b0;
    acc      = '0;
    neg      = 1'b0;
    is_int   = 1'b1;
  endfunction

  function automatic void clear_state();
    in_cs   = 1'b0;
    mode    = SM_IDLE;
    depth   = 0;
    stopped = 1'b0;
    clear_token();
  endfunction

  // Type 1 integer forms: one byte, two bytes, or FF plus a 32-bit word.
  function automatic void encode_number(logic [31:0] v);
    logic        sgn;
    logic [31:0] mag;
    sgn = v[31];
    mag = sgn ? 32'd0 - v : v;
    if (v == 32'h8000_0000 || mag > 32'd1131) begin
      emit(CH_UC_F, ST_CHAR);
      emit(CH_UC_F, ST_CHAR);
      emit_hex(v, 8);
    end else if (mag <= 32'd107) begin
      emit_hex(sgn ? 32'd139 - mag : 32'd139 + mag, 2);
    end else begin
      emit_hex((sgn ? 32'hFB00 : 32'hF700) + mag - 32'd108, 4);
    end
  endfunction

  function automatic void encode_command();
    bit same;
    if (!tok_long) begin
      for (int k = 0; k < NUM_CMDS; k++) begin
        same = CMD_NAME[k].len() == tok_len;
        for (int i = 0; i < tok_len && same; i++)
          if (CMD_NAME[k][i] != tok[i]) same = 0;
        if (same) begin
          if (k >= CMD_ESC_FIRST) begin
            emit(8'h30, ST_CHAR);
            emit(CH_UC_C, ST_CHAR);
          end
          emit_hex({24'd0, CMD_CODE[k]}, 2);
          return;
        end
      end
    end
    fail_with(ST_UNKNOWN_CMD);
  endfunction

  function automatic void token_add(logic [7:0] c);
    if (tok_len == 0 && (c == CH_PLUS || c == CH_MINUS))
      neg = (c == CH_MINUS);
    else if (c >= CH_ZERO && c <= CH_NINE)
      acc = acc * 32'd10 + {24'd0, c - CH_ZERO};
    else
      is_int = 1'b0;
    if (tok_len < MAX_TOKEN) begin
      tok[tok_len] = c;
      tok_len++;
    end else begin
      tok_long = 1'b1;
    end
  endfunction

  function automatic void close_token();
    if (in_cs) begin
      if (is_int) encode_number(neg ? 32'd0 - acc : acc);
      else encode_command();
    end
    clear_token();
    mode = SM_IDLE;
  endfunction

  function automatic void idle_byte(logic [7:0] c);
    if (is_ws(c)) begin
      if (!in_cs) emit(c, ST_CHAR);
      return;
    end
    case (c)
      CH_PCT: begin
        if (!in_cs) emit(c, ST_CHAR);
        mode = SM_COMMENT;
      end
      CH_LPAR: begin
        if (in_cs) begin
          fail_with(ST_TYPECHECK);
        end else begin
          emit(c, ST_CHAR);
          depth = 1;
          mode  = SM_STRING;
        end
      end
      CH_RPAR: fail_with(ST_STRAY_PAREN);
      CH_LT: begin
        if (in_cs) begin
          fail_with(ST_NESTED_CS);
        end else begin
          emit(c, ST_CHAR);
          in_cs = 1'b1;
        end
      end
      CH_GT: begin
        if (!in_cs) begin
          fail_with(ST_STRAY_ANGLE);
        end else begin
          emit(c, ST_CHAR);
          in_cs = 1'b0;
        end
      end
      CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC: begin
        if (in_cs) fail_with(ST_TYPECHECK);
        else emit(c, ST_CHAR);
      end
      default: begin
        clear_token();
        mode = SM_TOKEN;
        if (in_cs) token_add(c);
        else emit(c, ST_CHAR);
      end
    endcase
  endfunction

  function automatic void string_byte(logic [7:0] c);
    longint unsigned dmax;
    dmax = (64'd1 << NEST_BITS) - 64'd1;
    emit(c, ST_CHAR);
    if (c == CH_BSLASH) begin
      mode = SM_ESCAPE;
    end else if (c == CH_LPAR) begin
      if (depth >= dmax) fail_with(ST_NEST_OVF);
      else depth++;
    end else if (c == CH_RPAR) begin
      if (depth > 0) depth--;
      if (depth == 0) mode = SM_IDLE;
    end
  endfunction

  // Predict the result items of one accepted input item.
  function automatic void run_item(logic [7:0] c, logic eoi);
    outcome_t o;
    step_q.delete();
    if (stopped) return;
    if (eoi) begin
      if (mode == SM_STRING || mode == SM_ESCAPE) begin
        fail_with(ST_EOF_STR);
      end else begin
        if (mode == SM_TOKEN) close_token();
        if (!stopped) fail_with(ST_DONE);
      end
    end else begin
      case (mode)
        SM_COMMENT: begin
          if (!in_cs) emit(c, ST_CHAR);
          if (c == CH_LF) mode = SM_IDLE;
        end
        SM_STRING: string_byte(c);
        SM_ESCAPE: begin
          emit(c, ST_CHAR);
          mode = SM_STRING;
        end
        SM_TOKEN: begin
          if (is_reg(c)) begin
            if (in_cs) token_add(c);
            else emit(c, ST_CHAR);
          end else begin
            close_token();
            if (!stopped) idle_byte(c);
          end
        end
        default: idle_byte(c);
      endcase
    end
    if (step_q.size() > 0) begin
      o = step_q[step_q.size() - 1];
      o.last = 1'b1;
      step_q[step_q.size() - 1] = o;
    end
    foreach (step_q[i]) result_q.push_back(step_q[i]);
  endfunction

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors_o++;
  endtask

  // Sample at the falling edge: a handshake seen here completes at the next
  // rising edge, and nothing changes in between.
  always @(negedge clk_i or negedge rst_ni) begin
    outcome_t w;
    if (!rst_ni) begin
      clear_state();
      result_q.delete();
      errors_o  = 0;
      checked_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          report($sformatf("result item %h/%0d/%b with none pending",
                           out_byte_i, status_i, last_i));
        end else begin
          w = result_q.pop_front();
          checked_o++;
          if (out_byte_i !== w.ch)
            report($sformatf("out_byte %h, want %h", out_byte_i, w.ch));
          if (status_i !== w.st)
            report($sformatf("status %0d, want %0d", status_i, w.st));
          if (last_i !== w.last)
            report($sformatf("last %b, want %b", last_i, w.last));
        end
      end
      if (in_valid_i && in_ready_i) run_item(in_byte_i, end_of_input_i);
    end
    pending_o = result_q.size();
  end

endmodule

// ===== verif/tb_charstring_assembler_stream.sv =====
// ----------------------------------------------------------------------------
// tb_charstring_assembler_stream
// Stream of PostScript text into the charstring assembler: directed cases,
// then random text shaped like fonts, ending in one chosen final status.
// ----------------------------------------------------------------------------
module tb_charstring_assembler_stream import csa_pkg::*;;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TEXT_ITEMS   = 300;
  localparam int DRAIN_CYCLES = 30;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       end_of_input_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic [3:0] status_o;
  logic       last_o;

  int errors;
  int pending;
  int checked;
  int cycles;
  int tx_idle;
  int rx_idle;
  bit rx_hold;
  int cmd_next;
  int end_kind;

  // Whole text stream, built before driving: byte plus end marker.
  logic [7:0] text_q [$];
  logic       eoi_q [$];
  string      ending;

  // Command names used to build charstring tokens.
  localparam string CMD_WORD [26] = '{
    "hstem", "vstem", "vmoveto", "rlineto", "hlineto", "vlineto", "rrcurveto",
    "closepath", "callsubr", "return", "escape", "hsbw", "endchar", "rmoveto",
    "hmoveto", "vhcurveto", "hvcurveto", "dotsection", "vstem3", "hstem3",
    "seac", "sbw", "div", "callothersubr", "pop", "setcurrentpoint"
  };
  localparam logic [7:0] WS_SET [6] = '{CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE};

  charstring_assembler_stream u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_input_i(end_of_input_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  charstring_assembler_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_input_i(end_of_input_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_i    (out_byte_o),
    .status_i      (status_o),
    .last_i        (last_o),
    .errors_o      (errors),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus the long hold-off below.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !rx_hold && ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // Hold the output off for a long stretch so the block backs up its input.
  initial begin
    rx_hold = 1'b0;
    repeat (400) @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (250) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  function automatic void put_byte(logic [7:0] b);
    text_q.push_back(b);
    eoi_q.push_back(1'b0);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  // End marker; the byte beside it is ignored, so make it random.
  function automatic void put_eoi();
    text_q.push_back(8'($urandom_range(0, 255)));
    eoi_q.push_back(1'b1);
  endfunction

  function automatic bit regular(logic [7:0] c);
    return !(c inside {CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE, CH_LPAR,
                       CH_RPAR, CH_LT, CH_GT, CH_LBRK, CH_RBRK, CH_LBRC,
                       CH_RBRC, CH_SLASH, CH_PCT});
  endfunction

  function automatic void put_space();
    put_byte(WS_SET[$urandom_range(0, 5)]);
  endfunction

  // Comment with arbitrary bytes up to the newline.
  function automatic void put_comment();
    logic [7:0] c;
    put_byte(CH_PCT);
    repeat ($urandom_range(0, 8)) begin
      c = 8'($urandom_range(0, 255));
      put_byte(c == CH_LF ? 8'h41 : c);
    end
    put_byte(CH_LF);
  endfunction

  // Parenthesised string: arbitrary bytes, escapes and one level of nesting.
  function automatic void put_string();
    logic [7:0] c;
    put_byte(CH_LPAR);
    repeat ($urandom_range(0, 10)) begin
      c = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
        0: begin
          put_byte(CH_BSLASH);
          put_byte(c);
        end
        1: begin
          put_byte(CH_LPAR);
          put_byte(c == CH_LPAR || c == CH_RPAR || c == CH_BSLASH ? 8'h7A : c);
          put_byte(CH_RPAR);
        end
        default: put_byte(c == CH_LPAR || c == CH_RPAR || c == CH_BSLASH ? 8'h20 : c);
      endcase
    end
    put_byte(CH_RPAR);
  endfunction

  function automatic void put_word();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) put_byte(CH_SLASH);
    repeat ($urandom_range(1, 6)) begin
      do c = 8'($urandom_range(0, 255)); while (!regular(c));
      put_byte(c);
    end
    put_space();
  endfunction

  // Integer text in charstring: every encoded size, sign forms and wrap.
  function automatic void put_number();
    string sgn;
    sgn = "";
    case ($urandom_range(0, 2))
      0: sgn = "-";
      1: sgn = "+";
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: put_text({sgn, $sformatf("%0d", $urandom_range(0, 107))});
      1: put_text({sgn, $sformatf("%0d", $urandom_range(108, 1131))});
      2: put_text({sgn, $sformatf("%0d", $urandom_range(1132, 1140))});
      3: put_text({sgn, $sformatf("%0d", $urandom)});
      4: begin
        put_text(sgn);
        repeat ($urandom_range(17, 22)) put_byte(8'($urandom_range(8'h30, 8'h39)));
      end
      default: put_text($urandom_range(0, 1) ? "-" : "+");
    endcase
  endfunction

  // Commands are taken from the table in turn so that all of them come up.
  function automatic void put_charstring();
    put_byte(CH_LT);
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1)) begin
        put_number();
      end else begin
        put_text(CMD_WORD[cmd_next]);
        cmd_next = (cmd_next + 1) % 26;
      end
      if ($urandom_range(0, 5) == 0) put_comment();
      else put_space();
    end
    put_byte(CH_GT);
  endfunction

  function automatic void build_directed();
    put_text("% header\n(a\\)b(c)d) /x [ ] { } w ");
    foreach (WS_SET[i]) put_byte(WS_SET[i]);
    put_text("<0 107 -107 108 1131 -1131 1132 -1132 + - -2147483648 2147483648 ");
    put_text("99999999999999999999 % in charstring > (\n");
    put_text("hstem dotsection callothersubr setcurrentpoint >\n");
  endfunction

  // Fill with random text, leaving room for the ending.
  function automatic void build_random(int reserve);
    while (text_q.size() + reserve < TEXT_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: put_charstring();
        5: put_string();
        6: put_comment();
        7, 9: put_word();
        default: put_byte($urandom_range(0, 1) ? CH_LBRK : CH_RBRC);
      endcase
      put_space();
    end
  endfunction

  // Exactly one final status ends the stream; later items are dropped.
  function automatic void build_ending(int kind);
    case (kind)
      0: begin
        ending = "done in comment";
        put_text("% tail");
        put_eoi();
      end
      1: begin
        ending = "done after open token";
        put_text("<-77");
        put_eoi();
      end
      2: begin
        ending = "end inside string";
        put_text("(open\\");
        put_eoi();
      end
      3: begin
        ending = "stray close paren";
        put_byte(CH_RPAR);
      end
      4: begin
        ending = "nested charstring";
        put_text("<<");
      end
      5: begin
        ending = "stray close angle";
        put_byte(CH_GT);
      end
      6: begin
        ending = "delimiter in charstring";
        put_byte(CH_LT);
        case ($urandom_range(0, 4))
          0: put_byte(CH_LPAR);
          1: put_byte(CH_LBRK);
          2: put_byte(CH_RBRK);
          3: put_byte(CH_LBRC);
          default: put_byte(CH_RBRC);
        endcase
      end
      7: begin
        ending = "unknown command";
        put_text($urandom_range(0, 1) ? "<abcdefghijklmnopqr " : "<5 moveto ");
      end
      8: begin
        ending = "nesting overflow";
        repeat (258) put_byte(CH_LPAR);
      end
      default: begin
        ending = "done in idle";
        put_eoi();
      end
    endcase
    // Items after the final status must give nothing.
    repeat (6) begin
      text_q.push_back(8'($urandom_range(0, 255)));
      eoi_q.push_back(1'($urandom_range(0, 1)));
    end
  endfunction

  // Drive the stream; idle rates change per third of the stream.
  task automatic drive_text();
    int third;
    for (int i = 0; i < text_q.size(); i++) begin
      third   = i * 3 / text_q.size();
      tx_idle = (third == 0) ? 26 : (third == 1) ? 67 : 0;
      rx_idle = (third == 0) ? 67 : (third == 1) ? 26 : 0;
      if ($urandom_range(0, 99) < tx_idle) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle);
      end
      in_valid_i     <= 1'b1;
      in_byte_i      <= text_q[i];
      end_of_input_i <= eoi_q[i];
      do @(negedge clk_i); while (!in_ready_o);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = 8'h00;
    end_of_input_i = 1'b0;
    cycles         = 0;
    tx_idle        = 26;
    rx_idle        = 67;
    cmd_next       = 0;
    end_kind       = $urandom_range(0, 9);
    build_directed();
    build_random((end_kind == 8) ? 270 : 30);
    build_ending(end_kind);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    drive_text();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d text items, checked %0d result items", text_q.size(), checked);
    $display("stream closed by: %s", ending);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
